FILE: rtl/ncint_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ncint_pkg;

  localparam int MAG_W         = 48;
  localparam int LIMB_W        = 24;
  localparam int G_BITS        = 30;
  localparam int SQUARINGS     = 5;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EXP_ITER_DEF  = 16;

  localparam logic signed [47:0] MAX48 = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] MIN48 = {1'b1, {47{1'b0}}};
  localparam logic signed [31:0] MAX32 = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] MIN32 = {1'b1, {31{1'b0}}};

  typedef enum logic [2:0] {
    CMD_CHANNEL = 3'd0,
    CMD_RAXIAL  = 3'd1,
    CMD_AXIAL   = 3'd2,
    CMD_INJECT  = 3'd3,
    CMD_INIT    = 3'd4,
    CMD_PROCESS = 3'd5,
    CMD_REINIT  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_REST    = 3'd0,
    CFG_CAP     = 3'd1,
    CFG_LEAK    = 3'd2,
    CFG_AXIAL_R = 3'd3,
    CFG_BIAS    = 3'd4,
    CFG_INIT_V  = 3'd5,
    CFG_DT      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  a;
    logic [MAG_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [2*MAG_W-1:0] prod;
  } mul_rsp_t;

  function automatic logic [47:0] mag49(input logic signed [48:0] v);
    logic signed [48:0] n;
    n = -v;
    return v[48] ? n[47:0] : v[47:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'(MAX48)) return MAX48;
    if (v < 50'(MIN48)) return MIN48;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'(MAX32)) return MAX32;
    if (v < 50'(MIN32)) return MIN32;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/neuron_compartment_integrator.sv
// Passive compartment integrator, fixed point with FRAC_BITS fraction bits.
// Input channel (in_valid_i/in_ready_o): one command transaction with two
// operands. Channel, axial, raxial and inject commands update the internal
// sums and give no result; init, process and reinit give one result
// transaction on the output channel (out_valid_o/out_ready_i).
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i; the user must
// write only while the block is idle, as the block itself does not enforce it.
// The arithmetic runs on one shared multiplier and one shared radix-2
// divider. Process skips the exponential series when the exponent is clamped,
// and takes a direct step when the conductance sum is not positive. One
// transaction is worked at a time; in_ready_o is high only in idle. A finished
// result sits in the output register; if the receiver stalls while the next
// result is ready, the block holds in its emit step until the old one is
// taken. Reset loads the register defaults, potential -0.06, all sums zero.
`timescale 1ns / 1ps
`default_nettype none

module neuron_compartment_integrator #(
  parameter int FRAC_BITS      = ncint_pkg::FRAC_BITS_DEF,
  parameter int EXP_ITERATIONS = ncint_pkg::EXP_ITER_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         in_cmd_i,
  input  wire logic signed [31:0] in_first_operand_i,
  input  wire logic signed [31:0] in_second_operand_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    out_report_kind_o,
  output logic signed [31:0]      out_potential_o,
  output logic signed [31:0]      out_membrane_current_o,
  output logic [30:0]             out_sender_resistance_o
);

  localparam int DW      = ncint_pkg::MAG_W + FRAC_BITS;
  localparam int IW      = $clog2(EXP_ITERATIONS + 1);
  localparam int GB      = ncint_pkg::G_BITS;
  localparam int ONE_INT = 1 << FRAC_BITS;
  localparam int RST_INT = -(6 * ONE_INT) / 100;
  localparam int DT_INT  = ONE_INT / 100;

  localparam logic signed [31:0] RST_V   = 32'(RST_INT);
  localparam logic signed [48:0] ONE_Q   = 49'(1) << FRAC_BITS;
  localparam logic signed [47:0] T_LIM   = 48'(32) << FRAC_BITS;
  localparam logic signed [32:0] SUM_ONE = 33'(1) << GB;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CH_W, ST_AX1, ST_AX2, ST_AX3,
    ST_PA1, ST_PA2, ST_PA3,
    ST_E1, ST_E2, ST_EXM, ST_EXD, ST_EXC, ST_EXS, ST_E6, ST_E7, ST_E8,
    ST_F1, ST_F2, ST_F3, ST_F4,
    ST_END, ST_EMIT
  } state_e;

  // configuration
  logic signed [31:0] rest_q, bias_q, init_q;
  logic [30:0]        cap_q, leak_q, ra_cfg_q, dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q   <= RST_V;
      cap_q    <= 31'(ONE_INT);
      leak_q   <= 31'(ONE_INT);
      ra_cfg_q <= 31'(ONE_INT);
      bias_q   <= '0;
      init_q   <= RST_V;
      dt_q     <= 31'(DT_INT);
    end else if (cfg_we_i) begin
      unique case (ncint_pkg::cfg_idx_e'(cfg_idx_i))
        ncint_pkg::CFG_REST:    rest_q   <= cfg_wdata_i;
        ncint_pkg::CFG_CAP:     cap_q    <= cfg_wdata_i[30:0];
        ncint_pkg::CFG_LEAK:    leak_q   <= cfg_wdata_i[30:0];
        ncint_pkg::CFG_AXIAL_R: ra_cfg_q <= cfg_wdata_i[30:0];
        ncint_pkg::CFG_BIAS:    bias_q   <= cfg_wdata_i;
        ncint_pkg::CFG_INIT_V:  init_q   <= cfg_wdata_i;
        ncint_pkg::CFG_DT:      dt_q     <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  state_e state_q;

  logic signed [31:0] mp_q, prev_q, op1_q, op2_q, ra_q;
  logic signed [47:0] drive_q, csum_q, cur_q, inj_q, a_q, tmp_q, vinf_q;
  logic [FRAC_BITS:0] x_q;
  logic [29:0]        r_q;
  logic signed [32:0] sum_q;
  logic [IW-1:0]      i_q;
  logic [2:0]         sq_q;
  logic               neg_q;
  logic [47:0]        mul_a_q, mul_b_q, div_d_q;
  logic               mul_go_q, div_go_q;
  logic [DW-1:0]      div_n_q;
  logic               emit_kind_q;

  logic               out_valid_q, out_kind_q;
  logic signed [31:0] out_pot_q, out_cur_q;
  logic [30:0]        out_sres_q;

  ncint_pkg::mul_req_t mul_req;
  ncint_pkg::mul_rsp_t mul_rsp;
  logic                div_done;
  logic [DW-1:0]       quot;

  assign mul_req.start = mul_go_q;
  assign mul_req.a     = mul_a_q;
  assign mul_req.b     = mul_b_q;

  ncint_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  ncint_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_n_q),
    .divisor_i  (div_d_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  logic [47:0]        mulq_mag, divq_mag, one_minus_x;
  logic signed [47:0] mulq_res, divq_res;
  logic [30:0]        cm;
  logic signed [48:0] ax_diff;
  logic [29:0]        r_next;
  logic [30:0]        y_clamp, y_new;

  always_comb begin
    mulq_mag = (|mul_rsp.prod[2*ncint_pkg::MAG_W-1:FRAC_BITS+47]) ? ncint_pkg::MAX48
             : {1'b0, mul_rsp.prod[FRAC_BITS+46:FRAC_BITS]};
    mulq_res = neg_q ? -mulq_mag : mulq_mag;
    divq_mag = (|quot[DW-1:47]) ? ncint_pkg::MAX48 : {1'b0, quot[46:0]};
    divq_res = neg_q ? -divq_mag : divq_mag;
    cm          = (cap_q == '0) ? 31'd1 : cap_q;
    ax_diff     = 49'(op2_q) - 49'(mp_q);
    r_next      = 30'(divq_res[FRAC_BITS+4:0]) << (25 - FRAC_BITS);
    one_minus_x = (48'(1) << FRAC_BITS) - 48'(x_q);
    y_new       = mul_rsp.prod[2*GB:GB];
    if (sum_q[32]) begin
      y_clamp = '0;
    end else if (sum_q > SUM_ONE) begin
      y_clamp = 31'(1) << GB;
    end else begin
      y_clamp = sum_q[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mp_q        <= RST_V;
      prev_q      <= '0;
      drive_q     <= '0;
      csum_q      <= '0;
      cur_q       <= '0;
      inj_q       <= '0;
      op1_q       <= '0;
      op2_q       <= '0;
      ra_q        <= '0;
      a_q         <= '0;
      tmp_q       <= '0;
      vinf_q      <= '0;
      x_q         <= '0;
      r_q         <= '0;
      sum_q       <= '0;
      i_q         <= '0;
      sq_q        <= '0;
      neg_q       <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      div_n_q     <= '0;
      div_d_q     <= '0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      emit_kind_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= 1'b0;
      out_pot_q   <= '0;
      out_cur_q   <= '0;
      out_sres_q  <= '0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (out_valid_q && out_ready_i && state_q != ST_EMIT) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op1_q <= in_first_operand_i;
            op2_q <= in_second_operand_i;
            unique case (ncint_pkg::cmd_e'(in_cmd_i))
              ncint_pkg::CMD_CHANNEL: begin
                mul_a_q  <= ncint_pkg::mag49(49'(in_first_operand_i));
                mul_b_q  <= ncint_pkg::mag49(49'(in_second_operand_i));
                neg_q    <= in_first_operand_i[31] ^ in_second_operand_i[31];
                mul_go_q <= 1'b1;
                state_q  <= ST_CH_W;
              end
              ncint_pkg::CMD_RAXIAL: begin
                if (in_first_operand_i != '0) begin
                  ra_q     <= in_first_operand_i;
                  div_n_q  <= DW'(ncint_pkg::mag49(49'(in_second_operand_i))) << FRAC_BITS;
                  div_d_q  <= ncint_pkg::mag49(49'(in_first_operand_i));
                  neg_q    <= in_first_operand_i[31] ^ in_second_operand_i[31];
                  div_go_q <= 1'b1;
                  state_q  <= ST_AX1;
                end
              end
              ncint_pkg::CMD_AXIAL: begin
                if (ra_cfg_q != '0) begin
                  ra_q     <= 32'(ra_cfg_q);
                  div_n_q  <= DW'(ncint_pkg::mag49(49'(in_second_operand_i))) << FRAC_BITS;
                  div_d_q  <= 48'(ra_cfg_q);
                  neg_q    <= in_second_operand_i[31];
                  div_go_q <= 1'b1;
                  state_q  <= ST_AX1;
                end
              end
              ncint_pkg::CMD_INJECT: begin
                inj_q <= ncint_pkg::sat48(50'(inj_q) + 50'(in_first_operand_i));
                cur_q <= ncint_pkg::sat48(50'(cur_q) + 50'(in_first_operand_i));
              end
              ncint_pkg::CMD_INIT: begin
                emit_kind_q <= 1'b1;
                state_q     <= ST_EMIT;
              end
              ncint_pkg::CMD_PROCESS: state_q <= ST_PA1;
              ncint_pkg::CMD_REINIT: begin
                mp_q        <= init_q;
                drive_q     <= '0;
                csum_q      <= 48'(leak_q);
                cur_q       <= '0;
                prev_q      <= '0;
                inj_q       <= '0;
                emit_kind_q <= 1'b0;
                state_q     <= ST_EMIT;
              end
              default: ;
            endcase
          end
        end
        ST_CH_W: begin
          if (mul_rsp.done) begin
            drive_q <= ncint_pkg::sat48(50'(drive_q) + 50'(mulq_res));
            csum_q  <= ncint_pkg::sat48(50'(csum_q) + 50'(op1_q));
            state_q <= ST_IDLE;
          end
        end
        ST_AX1: begin
          if (div_done) begin
            drive_q  <= ncint_pkg::sat48(50'(drive_q) + 50'(divq_res));
            div_n_q  <= DW'(ncint_pkg::mag49(ONE_Q)) << FRAC_BITS;
            div_d_q  <= ncint_pkg::mag49(49'(ra_q));
            neg_q    <= ra_q[31];
            div_go_q <= 1'b1;
            state_q  <= ST_AX2;
          end
        end
        ST_AX2: begin
          if (div_done) begin
            csum_q   <= ncint_pkg::sat48(50'(csum_q) + 50'(divq_res));
            div_n_q  <= DW'(ncint_pkg::mag49(ax_diff)) << FRAC_BITS;
            div_d_q  <= ncint_pkg::mag49(49'(ra_q));
            neg_q    <= ax_diff[48] ^ ra_q[31];
            div_go_q <= 1'b1;
            state_q  <= ST_AX3;
          end
        end
        ST_AX3: begin
          if (div_done) begin
            cur_q   <= ncint_pkg::sat48(50'(cur_q) + 50'(divq_res));
            state_q <= ST_IDLE;
          end
        end
        ST_PA1: begin
          a_q     <= ncint_pkg::sat48(50'(drive_q) + 50'(bias_q));
          state_q <= ST_PA2;
        end
        ST_PA2: begin
          a_q      <= ncint_pkg::sat48(50'(a_q) + 50'(inj_q));
          mul_a_q  <= ncint_pkg::mag49(49'(rest_q));
          mul_b_q  <= 48'(leak_q);
          neg_q    <= rest_q[31];
          mul_go_q <= 1'b1;
          state_q  <= ST_PA3;
        end
        ST_PA3: begin
          if (mul_rsp.done) begin
            a_q      <= ncint_pkg::sat48(50'(a_q) + 50'(mulq_res));
            mul_go_q <= 1'b1;
            if (!csum_q[47] && csum_q != '0) begin
              mul_a_q <= ncint_pkg::mag49(49'(csum_q));
              mul_b_q <= 48'(dt_q);
              neg_q   <= 1'b0;
              state_q <= ST_E1;
            end else begin
              mul_a_q <= ncint_pkg::mag49(49'(mp_q));
              mul_b_q <= ncint_pkg::mag49(49'(csum_q));
              neg_q   <= mp_q[31] ^ csum_q[47];
              state_q <= ST_F1;
            end
          end
        end
        ST_E1: begin
          if (mul_rsp.done) begin
            div_n_q  <= DW'(ncint_pkg::mag49(49'(mulq_res))) << FRAC_BITS;
            div_d_q  <= 48'(cm);
            neg_q    <= mulq_res[47];
            div_go_q <= 1'b1;
            state_q  <= ST_E2;
          end
        end
        ST_E2: begin
          if (div_done) begin
            if (divq_res >= T_LIM) begin
              x_q      <= '0;
              div_n_q  <= DW'(ncint_pkg::mag49(49'(a_q))) << FRAC_BITS;
              div_d_q  <= ncint_pkg::mag49(49'(csum_q));
              neg_q    <= a_q[47] ^ csum_q[47];
              div_go_q <= 1'b1;
              state_q  <= ST_E6;
            end else begin
              r_q      <= r_next;
              sum_q    <= SUM_ONE;
              i_q      <= IW'(1);
              mul_a_q  <= 48'(1) << GB;
              mul_b_q  <= 48'(r_next);
              mul_go_q <= 1'b1;
              state_q  <= ST_EXM;
            end
          end
        end
        ST_EXM: begin
          if (mul_rsp.done) begin
            div_n_q  <= DW'(mul_rsp.prod[2*GB-1:GB]);
            div_d_q  <= 48'(i_q);
            div_go_q <= 1'b1;
            state_q  <= ST_EXD;
          end
        end
        ST_EXD: begin
          if (div_done) begin
            sum_q <= i_q[0] ? sum_q - 33'(quot[GB:0]) : sum_q + 33'(quot[GB:0]);
            if (i_q == IW'(EXP_ITERATIONS)) begin
              state_q <= ST_EXC;
            end else begin
              i_q      <= i_q + IW'(1);
              mul_a_q  <= 48'(quot[GB:0]);
              mul_b_q  <= 48'(r_q);
              mul_go_q <= 1'b1;
              state_q  <= ST_EXM;
            end
          end
        end
        ST_EXC: begin
          mul_a_q  <= 48'(y_clamp);
          mul_b_q  <= 48'(y_clamp);
          sq_q     <= '0;
          mul_go_q <= 1'b1;
          state_q  <= ST_EXS;
        end
        ST_EXS: begin
          if (mul_rsp.done) begin
            if (sq_q == 3'(ncint_pkg::SQUARINGS - 1)) begin
              x_q      <= y_new[GB:GB-FRAC_BITS];
              div_n_q  <= DW'(ncint_pkg::mag49(49'(a_q))) << FRAC_BITS;
              div_d_q  <= ncint_pkg::mag49(49'(csum_q));
              neg_q    <= a_q[47] ^ csum_q[47];
              div_go_q <= 1'b1;
              state_q  <= ST_E6;
            end else begin
              sq_q     <= sq_q + 3'd1;
              mul_a_q  <= 48'(y_new);
              mul_b_q  <= 48'(y_new);
              mul_go_q <= 1'b1;
            end
          end
        end
        ST_E6: begin
          if (div_done) begin
            vinf_q   <= divq_res;
            mul_a_q  <= ncint_pkg::mag49(49'(mp_q));
            mul_b_q  <= 48'(x_q);
            neg_q    <= mp_q[31];
            mul_go_q <= 1'b1;
            state_q  <= ST_E7;
          end
        end
        ST_E7: begin
          if (mul_rsp.done) begin
            tmp_q    <= mulq_res;
            mul_a_q  <= ncint_pkg::mag49(49'(vinf_q));
            mul_b_q  <= one_minus_x;
            neg_q    <= vinf_q[47];
            mul_go_q <= 1'b1;
            state_q  <= ST_E8;
          end
        end
        ST_E8: begin
          if (mul_rsp.done) begin
            mp_q    <= ncint_pkg::sat32(50'(tmp_q) + 50'(mulq_res));
            state_q <= ST_END;
          end
        end
        ST_F1: begin
          if (mul_rsp.done) begin
            a_q     <= ncint_pkg::sat48(50'(a_q) - 50'(mulq_res));
            state_q <= ST_F2;
          end
        end
        ST_F2: begin
          mul_a_q  <= ncint_pkg::mag49(49'(a_q));
          mul_b_q  <= 48'(dt_q);
          neg_q    <= a_q[47];
          mul_go_q <= 1'b1;
          state_q  <= ST_F3;
        end
        ST_F3: begin
          if (mul_rsp.done) begin
            div_n_q  <= DW'(ncint_pkg::mag49(49'(mulq_res))) << FRAC_BITS;
            div_d_q  <= 48'(cm);
            neg_q    <= mulq_res[47];
            div_go_q <= 1'b1;
            state_q  <= ST_F4;
          end
        end
        ST_F4: begin
          if (div_done) begin
            mp_q    <= ncint_pkg::sat32(50'(mp_q) + 50'(divq_res));
            state_q <= ST_END;
          end
        end
        ST_END: begin
          drive_q     <= '0;
          csum_q      <= 48'(leak_q);
          prev_q      <= ncint_pkg::sat32(50'(cur_q));
          cur_q       <= '0;
          inj_q       <= '0;
          emit_kind_q <= 1'b0;
          state_q     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= emit_kind_q;
            out_pot_q   <= mp_q;
            out_cur_q   <= prev_q;
            out_sres_q  <= emit_kind_q ? ra_cfg_q : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o              = (state_q == ST_IDLE);
  assign out_valid_o             = out_valid_q;
  assign out_report_kind_o       = out_kind_q;
  assign out_potential_o         = out_pot_q;
  assign out_membrane_current_o  = out_cur_q;
  assign out_sender_resistance_o = out_sres_q;

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_go_q && div_go_q))
    else $error("multiplier and divider started together");

  a_kind0_sres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_report_kind_o) |-> (out_sender_resistance_o == '0))
    else $error("potential report carries a resistance");

  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> !in_ready_o)
    else $error("multiplier finished while idle");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> !in_ready_o)
    else $error("divider finished while idle");

endmodule

`default_nettype wire

FILE: rtl/ncint_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module ncint_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ncint_pkg::mul_req_t req_i,
  output ncint_pkg::mul_rsp_t      rsp_o
);

  localparam int LW = ncint_pkg::LIMB_W;
  localparam int PW = 2 * ncint_pkg::MAG_W;

  logic          busy_q;
  logic          done_q;
  logic [1:0]    cnt_q;
  logic [PW-1:0] acc_q;

  logic [LW-1:0]   a_limb;
  logic [LW-1:0]   b_limb;
  logic [2*LW-1:0] pp;
  logic [PW-1:0]   pp_sh;

  // partial products, one 24x24 per cycle
  always_comb begin
    a_limb = cnt_q[1] ? req_i.a[2*LW-1:LW] : req_i.a[LW-1:0];
    b_limb = cnt_q[0] ? req_i.b[2*LW-1:LW] : req_i.b[LW-1:0];
    pp     = (2*LW)'(a_limb) * (2*LW)'(b_limb);
    pp_sh  = PW'(pp) << (LW * (32'(cnt_q[1]) + 32'(cnt_q[0])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= acc_q + pp_sh;
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

FILE: rtl/ncint_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ncint_div #(
  parameter int DW = ncint_pkg::MAG_W + ncint_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [47:0]   divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [47:0]   rem_q;
  logic [DW-1:0] quo_q;

  logic [48:0] trial;
  logic [48:0] diff;
  logic        ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    ge    = trial >= {1'b0, divisor_i};
    diff  = trial - {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[47:0] : trial[47:0];
        quo_q <= {quo_q[DW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire
